// ===== hdl/ppm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared types, constants and the sequencer control store of the PPM decoder.
// ----------------------------------------------------------------------------
package ppm_pkg;

  // Field widths
  localparam int unsigned EDGE_TIME_W = 32;
  localparam int unsigned CHANNEL_W   = 4;
  localparam int unsigned PULSE_W     = 16;
  localparam int unsigned PERCENT_W   = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned SLOT_IDX_W  = 4;
  localparam int unsigned PC_W        = 4;

  // Defaults
  localparam int unsigned NUM_CHANNELS_DEF = 8;
  localparam logic [15:0] GAP_RESET = 16'd2500;
  localparam logic [15:0] MIN_RESET = 16'd1000;
  localparam logic [15:0] MAX_RESET = 16'd2000;
  localparam logic [15:0] MID_TIME  = 16'd1500;

  // Percent constants
  localparam logic signed [7:0] PCT_LOW  = -8'sd100;
  localparam logic signed [7:0] PCT_HIGH = 8'sd100;
  localparam logic [7:0]        PCT_BIAS = 8'd100;
  localparam logic [7:0]        PCT_SCALE = 8'd200;

  // Request kinds
  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 2'd2;

  // Status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_CH  = 1'b1;

  // Divider runs one quotient bit per step, quotient fits in 8 bits
  localparam logic [2:0] DIV_LAST = 3'd7;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_LOAD  = 4'd1,
    OP_SCALE = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_PCT   = 4'd5,
    OP_EMIT  = 4'd6,
    OP_DIFF  = 4'd7,
    OP_SLOT  = 4'd8
  } op_e;

  // Jump conditions: taken -> target, else next step
  typedef enum logic [2:0] {
    C_NEXT    = 3'd0,
    C_ALWAYS  = 3'd1,
    C_NOREQ   = 3'd2,
    C_EDGE    = 3'd3,
    C_BAD     = 3'd4,
    C_CLAMP   = 3'd5,
    C_DIVMORE = 3'd6,
    C_OUTBUSY = 3'd7
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ucode_t;

  // Step addresses
  localparam logic [PC_W-1:0] S_FETCH  = 4'd0;
  localparam logic [PC_W-1:0] S_DECODE = 4'd1;
  localparam logic [PC_W-1:0] S_LOAD   = 4'd2;
  localparam logic [PC_W-1:0] S_SCALE  = 4'd3;
  localparam logic [PC_W-1:0] S_MUL    = 4'd4;
  localparam logic [PC_W-1:0] S_DIV    = 4'd5;
  localparam logic [PC_W-1:0] S_PCT    = 4'd6;
  localparam logic [PC_W-1:0] S_EMIT   = 4'd7;
  localparam logic [PC_W-1:0] S_DONE   = 4'd8;
  localparam logic [PC_W-1:0] S_DIFF   = 4'd9;
  localparam logic [PC_W-1:0] S_SLOT   = 4'd10;

  // Control store
  function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      S_FETCH:  w = '{op: OP_NONE,  cond: C_NOREQ,   target: S_FETCH};
      S_DECODE: w = '{op: OP_NONE,  cond: C_EDGE,    target: S_DIFF};
      S_LOAD:   w = '{op: OP_LOAD,  cond: C_BAD,     target: S_EMIT};
      S_SCALE:  w = '{op: OP_SCALE, cond: C_CLAMP,   target: S_EMIT};
      S_MUL:    w = '{op: OP_MUL,   cond: C_NEXT,    target: S_FETCH};
      S_DIV:    w = '{op: OP_DIV,   cond: C_DIVMORE, target: S_DIV};
      S_PCT:    w = '{op: OP_PCT,   cond: C_NEXT,    target: S_FETCH};
      S_EMIT:   w = '{op: OP_EMIT,  cond: C_OUTBUSY, target: S_EMIT};
      S_DONE:   w = '{op: OP_NONE,  cond: C_ALWAYS,  target: S_FETCH};
      S_DIFF:   w = '{op: OP_DIFF,  cond: C_NEXT,    target: S_FETCH};
      S_SLOT:   w = '{op: OP_SLOT,  cond: C_ALWAYS,  target: S_FETCH};
      default:  w = '{op: OP_NONE,  cond: C_ALWAYS,  target: S_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/ppm_intf.sv =====
// ----------------------------------------------------------------------------
// ppm_intf
// Valid/ready channels of the PPM decoder: request, response, register write.
// ----------------------------------------------------------------------------
interface ppm_req_if;
  import ppm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [EDGE_TIME_W-1:0] edge_time;
  logic [CHANNEL_W-1:0]   channel;

  modport source (output valid, req_type, edge_time, channel, input ready);
  modport sink   (input valid, req_type, edge_time, channel, output ready);
endinterface

interface ppm_rsp_if;
  import ppm_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [PULSE_W-1:0]          pulse_time;
  logic signed [PERCENT_W-1:0] percent;
  logic                        status;

  modport source (output valid, pulse_time, percent, status, input ready);
  modport sink   (input valid, pulse_time, percent, status, output ready);
endinterface

interface ppm_cfg_if;
  import ppm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== hdl/ppm_channel_decoder_top.sv =====
// ----------------------------------------------------------------------------
// ppm_channel_decoder_top
// RC pulse-position receiver: times edges into channel slots, answers reads.
// ----------------------------------------------------------------------------
// Usage:
//   req_i  : one request per handshake. An edge request (req_type 0) carries
//            the microsecond stamp of a falling edge; a read request
//            (req_type 1) names a channel 1..NUM_CHANNELS.
//   rsp_o  : one response per read request (pulse time, percent, status);
//            edge requests give no response.
//   cfg_i  : register writes (0 frame gap, 1 min pulse, 2 max pulse), always
//            ready; write only while no request is in flight.
// Timing: a microcoded sequencer runs one request at a time. An edge steps
//   through fetch, decode, diff and slot; a read steps through fetch, decode,
//   load, scale, multiply, the 8-step restoring divider (one quotient bit per
//   step), bias, emit and done. A bad channel goes from load to emit, and a
//   clamped value skips the divider and goes from scale to emit. A read
//   response is offered once its emit step has loaded the output register.
// Stall: the response register holds a finished result until taken; edges
//   keep being accepted meanwhile, a further read waits in its emit step.
// Reset: registers return to their defaults, every slot to 1500 us, the
//   edge stamp and slot index to zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
module ppm_channel_decoder_top #(
  parameter int unsigned NUM_CHANNELS = ppm_pkg::NUM_CHANNELS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ppm_req_if.sink       req_i,
  ppm_rsp_if.source     rsp_o,
  ppm_cfg_if.sink       cfg_i
);
  import ppm_pkg::*;

  localparam int unsigned SlotAw = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [SLOT_IDX_W-1:0] NumCh = SLOT_IDX_W'(NUM_CHANNELS);

  // Sequencer
  logic [PC_W-1:0] pc_q, pc_d;
  ucode_t          uw;
  logic            take;

  // Latched request
  logic                   req_type_q;
  logic [EDGE_TIME_W-1:0] edge_time_q;
  logic [CHANNEL_W-1:0]   channel_q;
  logic                   req_acc;

  // Configuration
  logic [15:0] gap_q, min_q, max_q;

  // Frame state
  logic [EDGE_TIME_W-1:0] last_q;
  logic [EDGE_TIME_W-1:0] diff_q;
  logic [SLOT_IDX_W-1:0]  slot_idx_q;
  logic [PULSE_W-1:0]     slot_q [NUM_CHANNELS];

  // Percent datapath
  logic [PULSE_W-1:0] val_q, num_q, span_q;
  logic [23:0]        rem_q, den_q;
  logic [7:0]         quo_q;
  logic [2:0]         cnt_q;
  logic               bad, below, above, flat, clamp;
  logic [SLOT_IDX_W-1:0] rd_idx;

  // Result staging and output register
  logic [PULSE_W-1:0]          res_pulse_q, out_pulse_q;
  logic signed [PERCENT_W-1:0] res_pct_q, out_pct_q;
  logic                        res_status_q, out_status_q;
  logic                        out_valid_q, out_busy;

  assign uw       = ucode_rom(pc_q);
  assign req_i.ready = (pc_q == S_FETCH);
  assign req_acc  = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_busy = out_valid_q && !rsp_o.ready;

  // Datapath flags
  assign bad    = (channel_q == '0) || (channel_q > NumCh);
  assign rd_idx = channel_q - 4'd1;
  assign below  = val_q < min_q;
  assign above  = val_q > max_q;
  assign flat   = (max_q == min_q);
  assign clamp  = below || above || flat;

  // Jump condition select
  always_comb begin
    case (uw.cond)
      C_NEXT:    take = 1'b0;
      C_ALWAYS:  take = 1'b1;
      C_NOREQ:   take = !req_acc;
      C_EDGE:    take = (req_type_q == REQ_EDGE);
      C_BAD:     take = bad;
      C_CLAMP:   take = clamp;
      C_DIVMORE: take = (cnt_q != DIV_LAST);
      C_OUTBUSY: take = out_busy;
      default:   take = 1'b1;
    endcase
    pc_d = take ? uw.target : pc_q + 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      req_type_q  <= req_i.req_type;
      edge_time_q <= req_i.edge_time;
      channel_q   <= req_i.channel;
    end
  end

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= GAP_RESET;
      min_q <= MIN_RESET;
      max_q <= MAX_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.reg_index)
        REG_FRAME_GAP: gap_q <= cfg_i.wdata;
        REG_MIN_PULSE: min_q <= cfg_i.wdata;
        REG_MAX_PULSE: max_q <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // Edge timing and slot fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= '0;
      slot_idx_q <= '0;
      for (int i = 0; i < int'(NUM_CHANNELS); i++) begin
        slot_q[i] <= MID_TIME;
      end
    end else begin
      if (uw.op == OP_DIFF) begin
        last_q <= edge_time_q;
      end
      if (uw.op == OP_SLOT) begin
        if (diff_q > {16'd0, gap_q}) begin
          slot_idx_q <= '0;
        end else if (slot_idx_q < NumCh) begin
          slot_q[slot_idx_q[SlotAw-1:0]] <= diff_q[PULSE_W-1:0];
          slot_idx_q <= slot_idx_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.op == OP_DIFF) begin
      diff_q <= edge_time_q - last_q;
    end
  end

  // Read path: load, scale, multiply, divide, bias
  always_ff @(posedge clk_i) begin
    case (uw.op)
      OP_LOAD: begin
        if (bad) begin
          res_pulse_q  <= '0;
          res_pct_q    <= '0;
          res_status_q <= STATUS_BAD_CH;
        end else begin
          val_q        <= slot_q[rd_idx[SlotAw-1:0]];
          res_pulse_q  <= slot_q[rd_idx[SlotAw-1:0]];
          res_status_q <= STATUS_OK;
        end
      end
      OP_SCALE: begin
        num_q <= val_q - min_q;
        span_q <= max_q - min_q;
        // clamped results; equal limits with val on both give PCT_LOW
        if (above && !below) begin
          res_pct_q <= PCT_HIGH;
        end else begin
          res_pct_q <= PCT_LOW;
        end
      end
      OP_MUL: begin
        rem_q <= {8'd0, num_q} * {16'd0, PCT_SCALE};
        den_q <= {1'b0, span_q, 7'd0};
        quo_q <= '0;
        cnt_q <= '0;
      end
      OP_DIV: begin
        if (rem_q >= den_q) begin
          rem_q <= rem_q - den_q;
          quo_q <= {quo_q[6:0], 1'b1};
        end else begin
          quo_q <= {quo_q[6:0], 1'b0};
        end
        den_q <= den_q >> 1;
        cnt_q <= cnt_q + 3'd1;
      end
      OP_PCT: begin
        res_pct_q <= signed'(quo_q - PCT_BIAS);
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uw.op == OP_EMIT && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.op == OP_EMIT && !out_busy) begin
      out_pulse_q  <= res_pulse_q;
      out_pct_q    <= res_pct_q;
      out_status_q <= res_status_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.pulse_time = out_pulse_q;
  assign rsp_o.percent    = out_pct_q;
  assign rsp_o.status     = out_status_q;

  // Checks
  a_slot_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_idx_q <= NumCh)
    else $error("slot index past channel count");

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == S_PCT) |-> (quo_q <= PCT_SCALE))
    else $error("percent quotient above scale");

  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pc_q == S_EMIT))
    else $error("response raised outside emit step");

  a_bad_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q == STATUS_BAD_CH) |->
      (out_pulse_q == '0 && out_pct_q == '0))
    else $error("bad channel response carries data");

endmodule
